[rtl/ciphertext_coeff_mod_alu_top_assert.svh]
// ----------------------------------------------------------------------------
// ciphertext_coeff_mod_alu_top_assert
// Assertion macros for the ciphertext coefficient ALU checker.
// ----------------------------------------------------------------------------
`ifndef CIPHERTEXT_COEFF_MOD_ALU_TOP_ASSERT_SVH
`define CIPHERTEXT_COEFF_MOD_ALU_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define CCMA_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset
`define CCMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ccma_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccma_pkg
// Types, constants and modular helper functions of the coefficient ALU.
// ----------------------------------------------------------------------------
package ccma_pkg;

    localparam int COEFF_BITS = 63;
    localparam int RED_STAGES = COEFF_BITS;
    localparam int MUL_STAGES = COEFF_BITS;
    localparam int LANE_STAGES = RED_STAGES + MUL_STAGES;

    typedef logic [COEFF_BITS-1:0] t_coeff;

    typedef enum logic [2:0] {
        KIND_ADD   = 3'd0,
        KIND_SUB   = 3'd1,
        KIND_NEG   = 3'd2,
        KIND_ADDP  = 3'd3,
        KIND_SUBP  = 3'd4,
        KIND_MULP  = 3'd5
    } t_kind;

    // What one lane hands to the merge stage
    typedef struct packed {
        t_coeff f;
        t_coeff s;
        t_coeff p;
        t_coeff prod;
    } t_lane_res;

    // One restoring step of x mod q: shift in the next bit, subtract q if it fits
    function automatic t_coeff red_step(t_coeff rem, logic b, t_coeff q);
        logic [COEFF_BITS:0] t;
        t = {rem, b};
        if (t >= {1'b0, q}) begin
            t = t - {1'b0, q};
        end
        return t[COEFF_BITS-1:0];
    endfunction

    function automatic t_coeff add_q(t_coeff x, t_coeff y, t_coeff q);
        logic [COEFF_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, q}) begin
            s = s - {1'b0, q};
        end
        return s[COEFF_BITS-1:0];
    endfunction

    // x + (q - y) stays below q, so wrapping arithmetic gives the right value
    function automatic t_coeff sub_q(t_coeff x, t_coeff y, t_coeff q);
        return (x >= y) ? (x - y) : (x + q - y);
    endfunction

    function automatic t_coeff neg_q(t_coeff x, t_coeff q);
        return (x == '0) ? '0 : (q - x);
    endfunction

    // One double-and-add step of the shift-and-add modular product
    function automatic t_coeff mul_step(t_coeff acc, t_coeff x, logic b, t_coeff q);
        t_coeff d;
        d = add_q(acc, acc, q);
        return b ? add_q(d, x, q) : d;
    endfunction

endpackage

[rtl/ciphertext_coeff_mod_alu_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ciphertext_coeff_mod_alu_top
// Coefficient-wise modular add/sub/negate/plain ops on RLWE ciphertext pairs.
//
//  channel   direction  handshake
//  in        sink       i_in_valid / o_in_stall
//  out       source     o_out_valid / i_out_stall
//  cfg       sink       i_cfg_valid / o_cfg_ready (always ready)
//
// One transaction per cycle while the output is not stalled; each passes through
// the bit-per-stage reduction and double-and-add pipelines in each lane.
// Synchronous active-low reset clears the valid pipeline; q resets to 2.
// A stalled output freezes the whole pipeline and stalls the input.
// ----------------------------------------------------------------------------
module ciphertext_coeff_mod_alu_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [2:0]       i_kind,
    input  ccma_pkg::t_coeff i_first_a,
    input  ccma_pkg::t_coeff i_first_b,
    input  ccma_pkg::t_coeff i_second_a,
    input  ccma_pkg::t_coeff i_second_b,
    input  ccma_pkg::t_coeff i_plain_coeff,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ccma_pkg::t_coeff o_out_a,
    output ccma_pkg::t_coeff o_out_b,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  ccma_pkg::t_coeff i_cfg_data
);

    localparam int N = ccma_pkg::LANE_STAGES;

    ccma_pkg::t_coeff    r_q;
    logic [N-1:0]        r_vld;
    logic [2:0]          r_kind [N];
    logic                r_out_valid;
    ccma_pkg::t_coeff    r_out_a;
    ccma_pkg::t_coeff    r_out_b;
    ccma_pkg::t_coeff    n_out_a;
    ccma_pkg::t_coeff    n_out_b;
    ccma_pkg::t_lane_res w_la;
    ccma_pkg::t_lane_res w_lb;
    logic                w_adv;

    assign w_adv       = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= ccma_pkg::t_coeff'(2);
        end else if (i_cfg_valid) begin
            r_q <= i_cfg_data;
        end
    end

    ccma_lane u_lane_a (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_q   (r_q),
        .i_f   (i_first_a),
        .i_s   (i_second_a),
        .i_p   (i_plain_coeff),
        .o_res (w_la)
    );

    ccma_lane u_lane_b (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_q   (r_q),
        .i_f   (i_first_b),
        .i_s   (i_second_b),
        .i_p   (i_plain_coeff),
        .o_res (w_lb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[N-2:0], i_in_valid};
            r_out_valid <= r_vld[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_kind[0] <= i_kind;
            for (int k = 1; k < N; k++) begin
                r_kind[k] <= r_kind[k-1];
            end
            r_out_a <= n_out_a;
            r_out_b <= n_out_b;
        end
    end

    // merge: pick the operation result from both lanes
    always_comb begin
        n_out_a = w_la.f;
        n_out_b = w_lb.f;
        unique case (r_kind[N-1])
            ccma_pkg::KIND_ADD: begin
                n_out_a = ccma_pkg::add_q(w_la.f, w_la.s, r_q);
                n_out_b = ccma_pkg::add_q(w_lb.f, w_lb.s, r_q);
            end
            ccma_pkg::KIND_SUB: begin
                n_out_a = ccma_pkg::sub_q(w_la.f, w_la.s, r_q);
                n_out_b = ccma_pkg::sub_q(w_lb.f, w_lb.s, r_q);
            end
            ccma_pkg::KIND_NEG: begin
                n_out_a = ccma_pkg::neg_q(w_la.f, r_q);
                n_out_b = ccma_pkg::neg_q(w_lb.f, r_q);
            end
            ccma_pkg::KIND_ADDP: begin
                n_out_b = ccma_pkg::add_q(w_lb.f, w_lb.p, r_q);
            end
            ccma_pkg::KIND_SUBP: begin
                n_out_b = ccma_pkg::sub_q(w_lb.f, w_lb.p, r_q);
            end
            ccma_pkg::KIND_MULP: begin
                n_out_a = w_la.prod;
                n_out_b = w_lb.prod;
            end
            default: begin
                n_out_a = w_la.f;
                n_out_b = w_lb.f;
            end
        endcase
        // modulus 0 or 1 is out of range: force zero
        if (r_q < ccma_pkg::t_coeff'(2)) begin
            n_out_a = '0;
            n_out_b = '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_a     = r_out_a;
    assign o_out_b     = r_out_b;

endmodule

[rtl/ccma_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccma_lane
// One component lane: bit-serial reduction of three operands mod q, then a
// double-and-add multiplier pipeline, one bit per stage.
// ----------------------------------------------------------------------------
module ccma_lane (
    input  logic               i_clk,
    input  logic               i_adv,
    input  ccma_pkg::t_coeff   i_q,
    input  ccma_pkg::t_coeff   i_f,
    input  ccma_pkg::t_coeff   i_s,
    input  ccma_pkg::t_coeff   i_p,
    output ccma_pkg::t_lane_res o_res
);

    localparam int W = ccma_pkg::COEFF_BITS;
    localparam int NR = ccma_pkg::RED_STAGES;
    localparam int NM = ccma_pkg::MUL_STAGES;

    // reduction stages: remainders and raw operands
    ccma_pkg::t_coeff r_frem [NR];
    ccma_pkg::t_coeff r_srem [NR];
    ccma_pkg::t_coeff r_prem [NR];
    ccma_pkg::t_coeff r_fraw [NR];
    ccma_pkg::t_coeff r_sraw [NR];
    ccma_pkg::t_coeff r_praw [NR];
    ccma_pkg::t_coeff n_frem [NR];
    ccma_pkg::t_coeff n_srem [NR];
    ccma_pkg::t_coeff n_prem [NR];
    ccma_pkg::t_coeff n_fraw [NR];
    ccma_pkg::t_coeff n_sraw [NR];
    ccma_pkg::t_coeff n_praw [NR];

    // multiplier stages
    ccma_pkg::t_coeff r_mf   [NM];
    ccma_pkg::t_coeff r_ms   [NM];
    ccma_pkg::t_coeff r_mp   [NM];
    ccma_pkg::t_coeff r_macc [NM];
    ccma_pkg::t_coeff n_mf   [NM];
    ccma_pkg::t_coeff n_ms   [NM];
    ccma_pkg::t_coeff n_mp   [NM];
    ccma_pkg::t_coeff n_macc [NM];

    genvar j;
    generate
        for (j = 0; j < NR; j++) begin : g_red
            if (j == 0) begin : g_first
                always_comb begin
                    n_fraw[j] = i_f;
                    n_sraw[j] = i_s;
                    n_praw[j] = i_p;
                    n_frem[j] = ccma_pkg::red_step('0, i_f[W-1], i_q);
                    n_srem[j] = ccma_pkg::red_step('0, i_s[W-1], i_q);
                    n_prem[j] = ccma_pkg::red_step('0, i_p[W-1], i_q);
                end
            end else begin : g_next
                always_comb begin
                    n_fraw[j] = r_fraw[j-1];
                    n_sraw[j] = r_sraw[j-1];
                    n_praw[j] = r_praw[j-1];
                    n_frem[j] = ccma_pkg::red_step(r_frem[j-1], r_fraw[j-1][W-1-j], i_q);
                    n_srem[j] = ccma_pkg::red_step(r_srem[j-1], r_sraw[j-1][W-1-j], i_q);
                    n_prem[j] = ccma_pkg::red_step(r_prem[j-1], r_praw[j-1][W-1-j], i_q);
                end
            end
        end

        for (j = 0; j < NM; j++) begin : g_mul
            if (j == 0) begin : g_first
                always_comb begin
                    n_mf[j]   = r_frem[NR-1];
                    n_ms[j]   = r_srem[NR-1];
                    n_mp[j]   = r_prem[NR-1];
                    n_macc[j] = ccma_pkg::mul_step('0, r_frem[NR-1],
                                                   r_prem[NR-1][W-1], i_q);
                end
            end else begin : g_next
                always_comb begin
                    n_mf[j]   = r_mf[j-1];
                    n_ms[j]   = r_ms[j-1];
                    n_mp[j]   = r_mp[j-1];
                    n_macc[j] = ccma_pkg::mul_step(r_macc[j-1], r_mf[j-1],
                                                   r_mp[j-1][W-1-j], i_q);
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_frem <= n_frem;
            r_srem <= n_srem;
            r_prem <= n_prem;
            r_fraw <= n_fraw;
            r_sraw <= n_sraw;
            r_praw <= n_praw;
            r_mf   <= n_mf;
            r_ms   <= n_ms;
            r_mp   <= n_mp;
            r_macc <= n_macc;
        end
    end

    assign o_res.f    = r_mf[NM-1];
    assign o_res.s    = r_ms[NM-1];
    assign o_res.p    = r_mp[NM-1];
    assign o_res.prod = r_macc[NM-1];

endmodule

[rtl/ccma_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccma_chk
// Port-level checks of the coefficient ALU stall behavior.
// ----------------------------------------------------------------------------
`include "ciphertext_coeff_mod_alu_top_assert.svh"

module ccma_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input ccma_pkg::t_coeff o_out_a,
    input ccma_pkg::t_coeff o_out_b
);

    `CCMA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_a) && $stable(o_out_b), "stalled output changed")
    `CCMA_ASSERT(a_empty_no_stall, !o_out_valid, !o_in_stall, "input stalled with empty output")
    `CCMA_ASSERT(a_taken_no_stall, o_out_valid && !i_out_stall, !o_in_stall,
        "input stalled while output drains")

endmodule

bind ciphertext_coeff_mod_alu_top ccma_chk u_ccma_chk (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the ciphertext coefficient modular ALU.
// A local predictor computes each expected (a, b) pair under the current
// modulus. Results are matched in order against a queue, with random input
// gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LATENCY = 2 * ccma_pkg::COEFF_BITS + 1;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [62:0] QMAX = {63{1'b1}};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_kind;
    ccma_pkg::t_coeff i_first_a, i_first_b, i_second_a, i_second_b, i_plain_coeff;
    logic        o_out_valid;
    logic        i_out_stall;
    ccma_pkg::t_coeff o_out_a, o_out_b;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    ccma_pkg::t_coeff i_cfg_data;

    typedef struct {
        ccma_pkg::t_coeff a;
        ccma_pkg::t_coeff b;
    } t_pair;

    t_pair  pending_pairs[$];
    ccma_pkg::t_coeff cur_q;
    int     errors;
    longint cycle_cnt = 0;
    int     send_idle_pct;
    int     stall_pct;

    ciphertext_coeff_mod_alu_top dut (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------- predictor ----------------
    function automatic ccma_pkg::t_coeff mod_add(ccma_pkg::t_coeff x, ccma_pkg::t_coeff y,
                                                 ccma_pkg::t_coeff q);
        logic [63:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, q}) begin
            s = s - {1'b0, q};
        end
        return s[62:0];
    endfunction

    function automatic ccma_pkg::t_coeff mod_sub(ccma_pkg::t_coeff x, ccma_pkg::t_coeff y,
                                                 ccma_pkg::t_coeff q);
        return (x >= y) ? x - y : x + (q - y);
    endfunction

    function automatic ccma_pkg::t_coeff mod_mul(ccma_pkg::t_coeff x, ccma_pkg::t_coeff y,
                                                 ccma_pkg::t_coeff q);
        ccma_pkg::t_coeff acc;
        acc = '0;
        for (int i = ccma_pkg::COEFF_BITS - 1; i >= 0; i--) begin
            acc = mod_add(acc, acc, q);
            if (y[i]) begin
                acc = mod_add(acc, x, q);
            end
        end
        return acc;
    endfunction

    function automatic t_pair predict_pair(logic [2:0] kind, ccma_pkg::t_coeff fa_in,
                                           ccma_pkg::t_coeff fb_in, ccma_pkg::t_coeff sa_in,
                                           ccma_pkg::t_coeff sb_in, ccma_pkg::t_coeff pc_in,
                                           ccma_pkg::t_coeff q);
        t_pair  r;
        ccma_pkg::t_coeff fa, fb, sa, sb, pc;
        if (q < 2) begin
            r.a = '0;
            r.b = '0;
            return r;
        end
        fa = fa_in % q;
        fb = fb_in % q;
        sa = sa_in % q;
        sb = sb_in % q;
        pc = pc_in % q;
        case (kind)
            ccma_pkg::KIND_ADD: begin
                r.a = mod_add(fa, sa, q);
                r.b = mod_add(fb, sb, q);
            end
            ccma_pkg::KIND_SUB: begin
                r.a = mod_sub(fa, sa, q);
                r.b = mod_sub(fb, sb, q);
            end
            ccma_pkg::KIND_NEG: begin
                r.a = (fa == 0) ? '0 : q - fa;
                r.b = (fb == 0) ? '0 : q - fb;
            end
            ccma_pkg::KIND_ADDP: begin
                r.a = fa;
                r.b = mod_add(fb, pc, q);
            end
            ccma_pkg::KIND_SUBP: begin
                r.a = fa;
                r.b = mod_sub(fb, pc, q);
            end
            ccma_pkg::KIND_MULP: begin
                r.a = mod_mul(fa, pc, q);
                r.b = mod_mul(fb, pc, q);
            end
            default: begin
                r.a = fa;
                r.b = fb;
            end
        endcase
        return r;
    endfunction

    // ---------------- result checker and stall driver ----------------
    always @(posedge i_clk) begin
        t_pair exp_pair;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("ciphertext_coeff_mod_alu_top regression: fail");
            $finish;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_pairs.size() == 0) begin
                    $error("unexpected result a=%0h b=%0h", o_out_a, o_out_b);
                    errors++;
                end else begin
                    exp_pair = pending_pairs.pop_front();
                    if (o_out_a !== exp_pair.a) begin
                        $error("out_a expected %0h actual %0h", exp_pair.a, o_out_a);
                        errors++;
                    end
                    if (o_out_b !== exp_pair.b) begin
                        $error("out_b expected %0h actual %0h", exp_pair.b, o_out_b);
                        errors++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ---------------- stimulus ----------------
    // valid stays high after the transaction; the next idle cycle or a drain drops it
    task automatic send_item(logic [2:0] kind, ccma_pkg::t_coeff fa, ccma_pkg::t_coeff fb,
                             ccma_pkg::t_coeff sa, ccma_pkg::t_coeff sb,
                             ccma_pkg::t_coeff pc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_first_a     <= fa;
        i_first_b     <= fb;
        i_second_a    <= sa;
        i_second_b    <= sb;
        i_plain_coeff <= pc;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pending_pairs.insert(pending_pairs.size(),
                             predict_pair(kind, fa, fb, sa, sb, pc, cur_q));
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (pending_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_modulus(ccma_pkg::t_coeff q);
        drain_pipeline();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= q;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        cur_q = q;
    endtask

    function automatic ccma_pkg::t_coeff rand_coeff();
        return ccma_pkg::t_coeff'({$urandom, $urandom});
    endfunction

    // mostly reduced operands, with some raw values and edge values
    function automatic ccma_pkg::t_coeff rand_operand(ccma_pkg::t_coeff q);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) begin
            return rand_coeff();
        end else if (sel == 1) begin
            return q - 1;
        end else if (sel == 2) begin
            return '0;
        end
        return (q < 2) ? rand_coeff() : rand_coeff() % q;
    endfunction

    task automatic test_reset_modulus();
        // reset modulus is 2
        send_item(ccma_pkg::KIND_ADD, 63'd1, 63'd1, 63'd1, 63'd0, 63'd0);
    endtask

    task automatic test_directed_extremes();
        write_modulus(QMAX);
        for (int k = 0; k < 8; k++) begin
            send_item(k[2:0], QMAX - 1, QMAX - 1, QMAX - 1, QMAX - 1, QMAX - 1);
        end
        for (int k = 0; k < 6; k++) begin
            send_item(k[2:0], '0, 1, QMAX - 1, '0, QMAX - 1);
        end
        // operands above q, and all-ones raw inputs
        write_modulus(63'd1000003);
        send_item(ccma_pkg::KIND_ADD, QMAX, 63'd1000003, QMAX, 63'd5, '0);
        send_item(ccma_pkg::KIND_MULP, QMAX, 63'd7, '0, '0, QMAX);
        send_item(3'd7, QMAX, 63'd2000010, '0, '0, '0);
        send_item(ccma_pkg::KIND_SUBP, 63'd0, 63'd0, '0, '0, 63'd1);
    endtask

    task automatic test_small_moduli();
        // out-of-range moduli zero and one give zero results
        write_modulus(63'd0);
        send_item(ccma_pkg::KIND_ADD, 63'd5, 63'd9, 63'd3, 63'd1, 63'd2);
        write_modulus(63'd1);
        send_item(ccma_pkg::KIND_MULP, QMAX, QMAX, QMAX, QMAX, QMAX);
        write_modulus(63'd2);
        for (int k = 0; k < 6; k++) begin
            send_item(k[2:0], 63'd1, 63'd1, 63'd1, 63'd0, 63'd1);
        end
    endtask

    task automatic test_random_phase(ccma_pkg::t_coeff q, int n_items, int idle_pct,
                                     int stl_pct);
        logic [2:0] kind;
        write_modulus(q);
        send_idle_pct = idle_pct;
        stall_pct     = stl_pct;
        for (int i = 0; i < n_items; i++) begin
            kind = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                             : 3'($urandom_range(5));
            send_item(kind, rand_operand(q), rand_operand(q), rand_operand(q),
                      rand_operand(q), rand_operand(q));
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial begin
        errors        = 0;
        cur_q         = 63'd2;
        send_idle_pct = 0;
        stall_pct     = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_out_stall   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_kind        = '0;
        i_first_a     = '0;
        i_first_b     = '0;
        i_second_a    = '0;
        i_second_b    = '0;
        i_plain_coeff = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_modulus();
        test_directed_extremes();
        test_small_moduli();
        test_random_phase(QMAX, 150, 0, 0);
        test_random_phase(rand_coeff() | 63'h4000_0000_0000_0000, 150, 66, 0);
        test_random_phase(63'd12289, 150, 0, 66);
        test_random_phase(rand_coeff() | 63'd2, 150, 20, 20);
        test_random_phase(63'd3, 100, 0, 0);
        drain_pipeline();

        if (errors == 0) begin
            $display("ciphertext_coeff_mod_alu_top regression: pass");
        end else begin
            $display("ciphertext_coeff_mod_alu_top regression: fail");
        end
        $finish;
    end

endmodule

[ciphertext_coeff_mod_alu_top.f]
+incdir+rtl
rtl/ccma_pkg.sv
rtl/ccma_lane.sv
rtl/ciphertext_coeff_mod_alu_top.sv
rtl/ccma_chk.sv
verif/testbench.sv
